FILE: hdl/ret_pkg.sv
// Package: shared types and constants for the radial envelope table unit.
package ret_pkg;

  localparam int MaxPlanes = 64;
  localparam int FracBits  = 8;
  localparam int ValW      = 24;
  localparam int ScaleW    = 16;
  localparam int ScaleFrac = 8;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_QUERY     = 2'd1,
    OP_TRANSFORM = 2'd2,
    OP_CLEAR     = 2'd3
  } op_t;

  // Divider request and response between the top level and the divider.
  typedef struct packed {
    logic        start;
    logic [63:0] num_mag;
    logic [23:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

endpackage

FILE: hdl/ret_ram.sv
// Generic single-port RAM with registered read.
module ret_ram #(
  parameter int Width = 24,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write, and registered read (a read during a write returns the old data)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/ret_div.sv
// Radix-2 restoring divider: 64-bit magnitude by 24-bit unsigned divisor.
module ret_div (
  input  logic               clk,
  input  logic               rst_n,
  input  ret_pkg::div_req_t  req,
  output ret_pkg::div_rsp_t  rsp
);

  logic [63:0] quo_r;
  logic [24:0] rem_r;
  logic [23:0] den_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [24:0] trial;
  logic [24:0] diff;

  assign trial = {rem_r[23:0], quo_r[63]};
  assign diff  = trial - {1'b0, den_r};

  // Shift one quotient bit per cycle while busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        quo_r  <= req.num_mag;
        den_r  <= req.den;
        rem_r  <= '0;
        cnt_r  <= 7'd0;
      end else if (busy_r) begin
        if (!diff[24]) begin
          rem_r <= diff;
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= trial;
          quo_r <= {quo_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

FILE: hdl/radial_envelope_table_unit.sv
// Top level: sequencer over the breakpoint memories, shared multiplier and divider.
// Queries that fall between two keys use the 64-step divider.
// Throughput: one transaction in flight; in_tready returns in the same cycle that the
//   result enters the output register, which waits while out_tready is low.
// Reset: rst_n synchronous, active low; empties the table, no clearing pass.
module radial_envelope_table_unit #(
  parameter int MAX_PLANES = ret_pkg::MaxPlanes,
  parameter int FRAC_BITS  = ret_pkg::FracBits
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[1:0], coord_x[25:2], coord_y[49:26], coord_z[73:50], value[97:74],
  // scale[113:98], zero fill [119:114]
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[0], radius[24:1], in_range[25], inside_res[26], zero fill [31:27]
  output logic [31:0]  out_tdata
);

  localparam int AW = $clog2(MAX_PLANES);
  localparam int CW = $clog2(MAX_PLANES + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_WT, S_SCAN_CHK, S_INS, S_OVW, S_SHIFT_RD, S_SHIFT_WT,
    S_SHIFT_WK, S_SHIFT_WR, S_Q_MUL, S_Q_DIV, S_Q_SQ1,
    S_Q_SQ2, S_Q_SQ3, S_T_RD, S_T_WT, S_T_MUL, S_T_WR, S_DONE
  } state_t;

  state_t state_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] idx_r;
  logic [1:0]  op_r;
  logic signed [23:0] x_r, y_r, z_r, v_r;
  logic signed [15:0] s_r;
  logic signed [23:0] k1_r, r1_r, k2_r, r2_r;
  logic signed [63:0] acc_r;
  logic [63:0] sq_r;
  logic [23:0] shk_r, shr_r;
  logic        neg_r;
  logic        div_go_r;
  logic        out_v_r;
  logic [31:0] out_d_r;
  logic [31:0] res_r;

  // Memory ports
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [23:0]   key_wd, rad_wd, key_rd, rad_rd;

  ret_ram #(.Width(24), .Depth(MAX_PLANES)) u_keys (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(key_wd), .rdata(key_rd));
  ret_ram #(.Width(24), .Depth(MAX_PLANES)) u_radii (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(rad_wd), .rdata(rad_rd));

  ret_pkg::div_req_t div_req;
  ret_pkg::div_rsp_t div_rsp;
  ret_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // Shared multiplier: 25x25 signed
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic signed [24:0] dr;
  logic signed [24:0] dz_q;
  logic [23:0] ax, ay, ar;
  assign dr   = 25'(r2_r) - 25'(r1_r);
  assign dz_q = 25'(z_r) - 25'(k1_r);
  assign ax = x_r[23] ? 24'(-x_r) : x_r;
  assign ay = y_r[23] ? 24'(-y_r) : y_r;
  assign ar = r1_r;

  always_comb begin
    mul_a = dr;
    mul_b = dz_q;
    case (state_r)
      S_Q_SQ1: begin mul_a = 25'({1'b0, ax}); mul_b = 25'({1'b0, ax}); end
      S_Q_SQ2: begin mul_a = 25'({1'b0, ay}); mul_b = 25'({1'b0, ay}); end
      S_Q_SQ3: begin mul_a = 25'({1'b0, ar}); mul_b = 25'({1'b0, ar}); end
      S_T_MUL: begin mul_a = 25'($signed(rad_rd)); mul_b = 25'(s_r); end
      default: ;
    endcase
  end

  // Transform rounding and saturation
  logic signed [49:0] t_sum;
  logic [49:0] t_mag;
  logic [49:0] t_quo;
  logic [23:0] t_res;
  assign t_sum = acc_r[49:0] + (50'(v_r) <<< ret_pkg::ScaleFrac);
  assign t_mag = t_sum[49] ? 50'(-t_sum) : t_sum;
  assign t_quo = (t_mag + (50'd1 << (ret_pkg::ScaleFrac - 1))) >> ret_pkg::ScaleFrac;
  always_comb begin
    if (!t_sum[49] && t_quo > 50'd8388607) t_res = 24'h7FFFFF;
    else if (t_sum[49] && t_quo > 50'd8388608) t_res = 24'h800000;
    else if (t_sum[49]) t_res = -t_quo[23:0];
    else t_res = t_quo[23:0];
  end

  // Memory address, write data
  always_comb begin
    mem_we   = 1'b0;
    mem_addr = idx_r[AW-1:0];
    key_wd   = z_r;
    rad_wd   = v_r;
    case (state_r)
      S_INS, S_OVW: mem_we = 1'b1;
      S_SHIFT_WR: begin
        mem_we = 1'b1; key_wd = shk_r; rad_wd = shr_r;
      end
      S_T_WR: begin mem_we = 1'b1; key_wd = k1_r; rad_wd = t_res; end
      default: ;
    endcase
  end

  // Divider request: magnitude plus half the divisor rounds to nearest
  logic [23:0] den;
  logic [23:0] qhalf;
  logic [63:0] nmag;
  assign den   = 24'(k2_r - k1_r);
  assign qhalf = den >> 1;
  assign nmag  = acc_r[63] ? 64'(-acc_r) : acc_r;
  assign div_req.start   = div_go_r;
  assign div_req.num_mag = nmag + 64'(qhalf);
  assign div_req.den     = den;

  logic [63:0] qr;
  logic signed [24:0] r_int;
  assign qr    = div_rsp.quo;
  assign r_int = neg_r ? 25'(r1_r) - 25'(qr) : 25'(r1_r) + 25'(qr);

  logic full;
  assign full = (cnt_r == CW'(MAX_PLANES));

  logic signed [23:0] neg_one;
  assign neg_one = -24'sd1 <<< FRAC_BITS;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      out_v_r  <= 1'b0;
      div_go_r <= 1'b0;
    end else begin
      div_go_r <= (state_r == S_Q_MUL);
      // Load the output register when the result is ready and the slot is free
      if (state_r == S_DONE && (!out_v_r || out_tready)) begin
        out_v_r <= 1'b1;
        out_d_r <= res_r;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            op_r <= in_tdata[1:0];
            x_r <= in_tdata[25:2];  y_r <= in_tdata[49:26];
            z_r <= in_tdata[73:50]; v_r <= in_tdata[97:74];
            s_r <= in_tdata[113:98];
            idx_r <= '0;
            res_r <= '0;
            case (in_tdata[1:0])
              ret_pkg::OP_CLEAR: begin cnt_r <= '0; state_r <= S_DONE; end
              ret_pkg::OP_TRANSFORM: state_r <= S_T_RD;
              default: state_r <= S_SCAN_RD;
            endcase
          end
        end
        // Walk to first key at or above z
        S_SCAN_RD: begin
          if (idx_r == cnt_r) begin
            if (op_r == ret_pkg::OP_INSERT) begin
              if (full) begin res_r[0] <= 1'b1; state_r <= S_DONE; end
              else state_r <= S_INS;
            end else begin
              res_r[24:1] <= neg_one; state_r <= S_DONE;
            end
          end else state_r <= S_SCAN_WT;
        end
        S_SCAN_WT: state_r <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if ($signed(key_rd) < z_r) begin
            k1_r <= key_rd; r1_r <= rad_rd;
            idx_r <= idx_r + CW'(1); state_r <= S_SCAN_RD;
          end else if (op_r == ret_pkg::OP_INSERT) begin
            if ($signed(key_rd) == z_r) state_r <= S_OVW;
            else if (full) begin res_r[0] <= 1'b1; state_r <= S_DONE; end
            else begin
              shk_r <= key_rd; shr_r <= rad_rd; state_r <= S_INS;
            end
          end else begin
            k2_r <= key_rd; r2_r <= rad_rd;
            if ($signed(key_rd) == z_r) begin
              r1_r <= rad_rd; state_r <= S_Q_SQ1;
            end else if (idx_r == '0) begin
              res_r[24:1] <= neg_one; state_r <= S_DONE;
            end else state_r <= S_Q_MUL;
          end
        end
        // Write insert entry; then ripple the tail up by one
        S_INS: begin
          if (idx_r == cnt_r) begin
            cnt_r <= cnt_r + CW'(1); state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + CW'(1); state_r <= S_SHIFT_RD;
          end
        end
        // Overwrite the radius of an existing key
        S_OVW: state_r <= S_DONE;
        S_SHIFT_RD: state_r <= S_SHIFT_WT;
        S_SHIFT_WT: state_r <= S_SHIFT_WK;
        S_SHIFT_WK: begin
          k1_r <= key_rd; r1_r <= rad_rd; state_r <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          shk_r <= k1_r; shr_r <= r1_r;
          if (idx_r == cnt_r) begin
            cnt_r <= cnt_r + CW'(1); state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + CW'(1); state_r <= S_SHIFT_RD;
          end
        end
        // Interpolate
        S_Q_MUL: begin
          acc_r <= 64'(mul_p);
          neg_r <= mul_p[49];
          state_r <= S_Q_DIV;
        end
        S_Q_DIV: begin
          if (div_rsp.done) begin
            r1_r <= r_int[23:0];
            state_r <= S_Q_SQ1;
          end
        end
        S_Q_SQ1: begin sq_r <= 64'(mul_p); state_r <= S_Q_SQ2; end
        S_Q_SQ2: begin sq_r <= sq_r + 64'(mul_p); state_r <= S_Q_SQ3; end
        S_Q_SQ3: begin
          res_r[24:1] <= r1_r;
          res_r[25]   <= 1'b1;
          res_r[26]   <= !r1_r[23] && (sq_r <= 64'(mul_p));
          state_r <= S_DONE;
        end
        // Rescale radii in place
        S_T_RD: begin
          if (idx_r == cnt_r) state_r <= S_DONE;
          else state_r <= S_T_WT;
        end
        S_T_WT: state_r <= S_T_MUL;
        S_T_MUL: begin
          k1_r <= key_rd; state_r <= S_T_WR;
          acc_r <= 64'(mul_p);
        end
        S_T_WR: begin idx_r <= idx_r + CW'(1); state_r <= S_T_RD; end
        S_DONE: begin
          if (!out_v_r || out_tready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

FILE: hdl/ret_checker.sv
// Port checker for the radial envelope table unit, bound to the top level.
module ret_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [31:0]  out_tdata
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Accepting an item closes the input
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted twice back to back");

  // A full flag never comes with query fields
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[25] && !out_tdata[26])
    else $error("full status with query result");

  // Inside only when in range
  a_ins: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[26] |-> out_tdata[25])
    else $error("inside without range");

endmodule

bind radial_envelope_table_unit ret_checker u_ret_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));
